@@ rtl/core/pl0lex_pkg.sv @@
`timescale 1ns / 1ps

package pl0lex_pkg;

   // longest identifier the result word can carry, and the defaults
   localparam int unsigned NAME_LIMIT          = 11;
   localparam int unsigned NAME_MAX_DEFAULT    = 11;
   localparam int unsigned DIGITS_MAX_DEFAULT  = 5;
   localparam int unsigned KW_COUNT            = 14;

   localparam int unsigned KIND_W   = 6;
   localparam int unsigned ERR_W    = 3;
   localparam int unsigned VALUE_W  = 17;
   localparam int unsigned LEN_W    = 4;

   // token numbers
   localparam logic [KIND_W-1:0] TOK_ERROR     = 6'd0;
   localparam logic [KIND_W-1:0] TOK_IDENT     = 6'd2;
   localparam logic [KIND_W-1:0] TOK_NUMBER    = 6'd3;
   localparam logic [KIND_W-1:0] TOK_PLUS      = 6'd4;
   localparam logic [KIND_W-1:0] TOK_MINUS     = 6'd5;
   localparam logic [KIND_W-1:0] TOK_MULT      = 6'd6;
   localparam logic [KIND_W-1:0] TOK_SLASH     = 6'd7;
   localparam logic [KIND_W-1:0] TOK_ODD       = 6'd8;
   localparam logic [KIND_W-1:0] TOK_EQL       = 6'd9;
   localparam logic [KIND_W-1:0] TOK_NEQ       = 6'd10;
   localparam logic [KIND_W-1:0] TOK_LES       = 6'd11;
   localparam logic [KIND_W-1:0] TOK_LEQ       = 6'd12;
   localparam logic [KIND_W-1:0] TOK_GTR       = 6'd13;
   localparam logic [KIND_W-1:0] TOK_GEQ       = 6'd14;
   localparam logic [KIND_W-1:0] TOK_LPAREN    = 6'd15;
   localparam logic [KIND_W-1:0] TOK_RPAREN    = 6'd16;
   localparam logic [KIND_W-1:0] TOK_COMMA     = 6'd17;
   localparam logic [KIND_W-1:0] TOK_SEMICOLON = 6'd18;
   localparam logic [KIND_W-1:0] TOK_PERIOD    = 6'd19;
   localparam logic [KIND_W-1:0] TOK_BECOMES   = 6'd20;
   localparam logic [KIND_W-1:0] TOK_BEGIN     = 6'd21;
   localparam logic [KIND_W-1:0] TOK_END       = 6'd22;
   localparam logic [KIND_W-1:0] TOK_IF        = 6'd23;
   localparam logic [KIND_W-1:0] TOK_THEN      = 6'd24;
   localparam logic [KIND_W-1:0] TOK_WHILE     = 6'd25;
   localparam logic [KIND_W-1:0] TOK_DO        = 6'd26;
   localparam logic [KIND_W-1:0] TOK_CALL      = 6'd27;
   localparam logic [KIND_W-1:0] TOK_CONST     = 6'd28;
   localparam logic [KIND_W-1:0] TOK_VAR       = 6'd29;
   localparam logic [KIND_W-1:0] TOK_PROCEDURE = 6'd30;
   localparam logic [KIND_W-1:0] TOK_WRITE     = 6'd31;
   localparam logic [KIND_W-1:0] TOK_READ      = 6'd32;
   localparam logic [KIND_W-1:0] TOK_ELSE      = 6'd33;

   // error codes
   localparam logic [ERR_W-1:0] ERR_NONE         = 3'd0;
   localparam logic [ERR_W-1:0] ERR_NAME_LONG    = 3'd1;
   localparam logic [ERR_W-1:0] ERR_NUMBER_LONG  = 3'd2;
   localparam logic [ERR_W-1:0] ERR_LETTER_AFTER = 3'd3;
   localparam logic [ERR_W-1:0] ERR_LONE_COLON   = 3'd4;
   localparam logic [ERR_W-1:0] ERR_INVALID      = 3'd5;
   localparam logic [ERR_W-1:0] ERR_OPEN_COMMENT = 3'd6;

   typedef logic [NAME_LIMIT-1:0][7:0] name_bytes_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]  token_kind;
      logic [ERR_W-1:0]   error_code;
      logic [VALUE_W-1:0] number_value;
      logic [LEN_W-1:0]   name_length;
      logic [63:0]        name_first_eight;
      logic [23:0]        name_last_three;
      logic               last_of_run;
   } rsp_type;

   // keyword text, right aligned, with its length and token
   localparam logic [71:0] KW_TEXT [KW_COUNT] = '{
      72'("const"), 72'("var"), 72'("procedure"), 72'("call"), 72'("begin"),
      72'("end"), 72'("if"), 72'("then"), 72'("else"), 72'("while"),
      72'("do"), 72'("read"), 72'("write"), 72'("odd")
   };
   localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
      4'd5, 4'd3, 4'd9, 4'd4, 4'd5, 4'd3, 4'd2, 4'd4, 4'd4, 4'd5, 4'd2, 4'd4, 4'd5, 4'd3
   };
   localparam logic [KIND_W-1:0] KW_TOK [KW_COUNT] = '{
      TOK_CONST, TOK_VAR, TOK_PROCEDURE, TOK_CALL, TOK_BEGIN, TOK_END, TOK_IF,
      TOK_THEN, TOK_ELSE, TOK_WHILE, TOK_DO, TOK_READ, TOK_WRITE, TOK_ODD
   };

   // first character into byte 0, zero padded
   function automatic name_bytes_type kw_bytes(logic [71:0] text, logic [LEN_W-1:0] len);
      name_bytes_type b;
      b = '0;
      for (int i = 0; i < 9; i++) begin
         if (i < int'(len)) begin
            b[i] = text[8*(int'(len)-1-i) +: 8];
         end
      end
      return b;
   endfunction

   function automatic rsp_type tok_result(logic [KIND_W-1:0] kind);
      rsp_type r;
      r = '0;
      r.token_kind = kind;
      return r;
   endfunction

   function automatic rsp_type err_result(logic [ERR_W-1:0] code);
      rsp_type r;
      r = '0;
      r.token_kind = TOK_ERROR;
      r.error_code = code;
      return r;
   endfunction

   function automatic rsp_type num_result(logic [VALUE_W-1:0] value);
      rsp_type r;
      r = '0;
      r.token_kind   = TOK_NUMBER;
      r.number_value = value;
      return r;
   endfunction

   // keyword match for letter-only words, else identifier
   function automatic rsp_type word_result(name_bytes_type name, logic [LEN_W-1:0] len,
                                           logic saw_digit);
      rsp_type r;
      logic    hit;
      r   = '0;
      hit = 1'b0;
      r.token_kind       = TOK_IDENT;
      r.name_length      = len;
      r.name_first_eight = name[7:0];
      r.name_last_three  = name[10:8];
      for (int k = 0; k < KW_COUNT; k++) begin
         if (!saw_digit && !hit && len == KW_LEN[k] &&
             name == kw_bytes(KW_TEXT[k], KW_LEN[k])) begin
            hit = 1'b1;
            r   = tok_result(KW_TOK[k]);
         end
      end
      return r;
   endfunction

endpackage

@@ rtl/core/pl0_lexer_with_comment_strip_top.sv @@
`timescale 1ns / 1ps

// channel  dir  handshake            word
// req_     in   req_valid/req_ready  pl0lex_pkg::req_type (source byte, end flag)
// rsp_     out  rsp_valid/rsp_ready  pl0lex_pkg::rsp_type (one token or error)
//
// one source byte is taken per cycle while req_ready is high; the scan state updates in the same cycle
// a byte yields zero, one or two tokens; two tokens leave one after the other
// since the result port moves one word a cycle while rsp_ready is high
// a two-deep queue of token pairs sits before the result port, req_ready is
// low only when both slots hold undelivered tokens
// reset is synchronous and returns the scanner to idle with the queue empty

module pl0_lexer_with_comment_strip_top #(
   parameter int unsigned NAME_MAX   = pl0lex_pkg::NAME_MAX_DEFAULT,
   parameter int unsigned DIGITS_MAX = pl0lex_pkg::DIGITS_MAX_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pl0lex_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pl0lex_pkg::rsp_type rsp_data
);

   localparam int unsigned CW = $clog2(NAME_MAX + 1);
   localparam int unsigned IW = $clog2(NAME_MAX);
   localparam int unsigned DW = $clog2(DIGITS_MAX + 1);
   localparam int unsigned VW = pl0lex_pkg::VALUE_W;

   // scan modes
   localparam logic [3:0] M_IDLE    = 4'd0;
   localparam logic [3:0] M_NAME    = 4'd1;
   localparam logic [3:0] M_NUMBER  = 4'd2;
   localparam logic [3:0] M_SLASH   = 4'd3;
   localparam logic [3:0] M_COMMENT = 4'd4;
   localparam logic [3:0] M_CSTAR   = 4'd5;
   localparam logic [3:0] M_LESS    = 4'd6;
   localparam logic [3:0] M_GREATER = 4'd7;
   localparam logic [3:0] M_COLON   = 4'd8;
   localparam logic [3:0] M_DISCARD = 4'd9;

   typedef struct packed {
      pl0lex_pkg::rsp_type first;
      pl0lex_pkg::rsp_type second;
      logic                two;
   } pair_type;

   // scanner state
   logic [3:0]                mode_ff, mode_in;
   logic [NAME_MAX-1:0][7:0]  store_ff, store_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic                      saw_ff, saw_in;
   logic [VW-1:0]             acc_ff, acc_in;
   logic [DW-1:0]             dcnt_ff, dcnt_in;

   // token pair queue
   pair_type                  q_ff [2];
   logic [1:0]                qcnt_ff, qcnt_in;
   logic                      head_ff, head_in;
   logic                      sel_ff, sel_in;

   logic [7:0]                c;
   logic                      is_let, is_dig, is_spc;
   logic                      start_tok;
   logic                      cont_v, start_v, flush_v;
   pl0lex_pkg::rsp_type       cont_r, start_r, flush_r;
   pl0lex_pkg::name_bytes_type name_old, name_new;
   pair_type                  pair;
   logic                      req_fire, push, rsp_fire, pop_pair;
   pl0lex_pkg::rsp_type       head_first, head_second;

   assign c      = req_data.char_in;
   assign is_let = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   assign is_dig = (c >= "0" && c <= "9");
   assign is_spc = (c == " ") || (c >= 8'd9 && c <= 8'd13);

   // identifier bytes padded to the result width, before and after this byte
   always_comb begin
      name_old = '0;
      name_new = '0;
      for (int i = 0; i < NAME_MAX; i++) begin
         name_old[i] = store_ff[i];
         name_new[i] = store_in[i];
      end
   end

   // one byte: finish the pending token, start a new one, then flush on end
   always_comb begin
      mode_in   = mode_ff;
      store_in  = store_ff;
      cnt_in    = cnt_ff;
      saw_in    = saw_ff;
      acc_in    = acc_ff;
      dcnt_in   = dcnt_ff;
      start_tok = 1'b0;
      cont_v    = 1'b0;
      cont_r    = '0;
      start_v   = 1'b0;
      start_r   = '0;
      flush_v   = 1'b0;
      flush_r   = '0;

      unique case (mode_ff)
         M_NAME: begin
            if (is_let || is_dig) begin
               if (cnt_ff >= CW'(NAME_MAX)) begin
                  cont_v  = 1'b1;
                  cont_r  = pl0lex_pkg::err_result(pl0lex_pkg::ERR_NAME_LONG);
                  mode_in = M_DISCARD;
               end else begin
                  store_in[cnt_ff[IW-1:0]] = c;
                  cnt_in = cnt_ff + CW'(1);
                  saw_in = saw_ff | is_dig;
               end
            end else begin
               cont_v    = 1'b1;
               cont_r    = pl0lex_pkg::word_result(name_old,
                              pl0lex_pkg::LEN_W'(cnt_ff), saw_ff);
               start_tok = 1'b1;
            end
         end
         M_NUMBER: begin
            if (is_dig) begin
               if (dcnt_ff >= DW'(DIGITS_MAX)) begin
                  cont_v  = 1'b1;
                  cont_r  = pl0lex_pkg::err_result(pl0lex_pkg::ERR_NUMBER_LONG);
                  mode_in = M_DISCARD;
               end else begin
                  // times ten as two shifts, plus the digit
                  acc_in  = (acc_ff << 3) + (acc_ff << 1) + {{(VW-4){1'b0}}, c[3:0]};
                  dcnt_in = dcnt_ff + DW'(1);
               end
            end else if (is_let) begin
               cont_v  = 1'b1;
               cont_r  = pl0lex_pkg::err_result(pl0lex_pkg::ERR_LETTER_AFTER);
               mode_in = M_DISCARD;
            end else begin
               cont_v    = 1'b1;
               cont_r    = pl0lex_pkg::num_result(acc_ff);
               start_tok = 1'b1;
            end
         end
         M_SLASH: begin
            if (c == "*") begin
               mode_in = M_COMMENT;
            end else begin
               cont_v    = 1'b1;
               cont_r    = pl0lex_pkg::tok_result(pl0lex_pkg::TOK_SLASH);
               start_tok = 1'b1;
            end
         end
         M_COMMENT: begin
            if (c == "*") begin
               mode_in = M_CSTAR;
            end
         end
         M_CSTAR: begin
            if (c == "/") begin
               mode_in = M_IDLE;
            end else if (c != "*") begin
               mode_in = M_COMMENT;
            end
         end
         M_LESS: begin
            cont_v = 1'b1;
            if (c == "=") begin
               cont_r  = pl0lex_pkg::tok_result(pl0lex_pkg::TOK_LEQ);
               mode_in = M_IDLE;
            end else if (c == ">") begin
               cont_r  = pl0lex_pkg::tok_result(pl0lex_pkg::TOK_NEQ);
               mode_in = M_IDLE;
            end else begin
               cont_r    = pl0lex_pkg::tok_result(pl0lex_pkg::TOK_LES);
               start_tok = 1'b1;
            end
         end
         M_GREATER: begin
            cont_v = 1'b1;
            if (c == "=") begin
               cont_r  = pl0lex_pkg::tok_result(pl0lex_pkg::TOK_GEQ);
               mode_in = M_IDLE;
            end else begin
               cont_r    = pl0lex_pkg::tok_result(pl0lex_pkg::TOK_GTR);
               start_tok = 1'b1;
            end
         end
         M_COLON: begin
            cont_v = 1'b1;
            if (c == "=") begin
               cont_r  = pl0lex_pkg::tok_result(pl0lex_pkg::TOK_BECOMES);
               mode_in = M_IDLE;
            end else begin
               cont_r  = pl0lex_pkg::err_result(pl0lex_pkg::ERR_LONE_COLON);
               mode_in = M_DISCARD;
            end
         end
         M_DISCARD: begin
            mode_in = M_DISCARD;
         end
         default: begin
            start_tok = 1'b1;
         end
      endcase

      if (start_tok) begin
         mode_in = M_IDLE;
         if (is_let) begin
            store_in    = '0;
            store_in[0] = c;
            cnt_in      = CW'(1);
            saw_in      = 1'b0;
            mode_in     = M_NAME;
         end else if (is_dig) begin
            acc_in  = {{(VW-4){1'b0}}, c[3:0]};
            dcnt_in = DW'(1);
            mode_in = M_NUMBER;
         end else if (!is_spc) begin
            start_v = 1'b1;
            case (c)
               "/": begin start_v = 1'b0; mode_in = M_SLASH;   end
               "<": begin start_v = 1'b0; mode_in = M_LESS;    end
               ">": begin start_v = 1'b0; mode_in = M_GREATER; end
               ":": begin start_v = 1'b0; mode_in = M_COLON;   end
               "+": start_r = pl0lex_pkg::tok_result(pl0lex_pkg::TOK_PLUS);
               "-": start_r = pl0lex_pkg::tok_result(pl0lex_pkg::TOK_MINUS);
               "*": start_r = pl0lex_pkg::tok_result(pl0lex_pkg::TOK_MULT);
               "=": start_r = pl0lex_pkg::tok_result(pl0lex_pkg::TOK_EQL);
               "(": start_r = pl0lex_pkg::tok_result(pl0lex_pkg::TOK_LPAREN);
               ")": start_r = pl0lex_pkg::tok_result(pl0lex_pkg::TOK_RPAREN);
               ",": start_r = pl0lex_pkg::tok_result(pl0lex_pkg::TOK_COMMA);
               ";": start_r = pl0lex_pkg::tok_result(pl0lex_pkg::TOK_SEMICOLON);
               ".": start_r = pl0lex_pkg::tok_result(pl0lex_pkg::TOK_PERIOD);
               default: begin
                  start_r = pl0lex_pkg::err_result(pl0lex_pkg::ERR_INVALID);
                  mode_in = M_DISCARD;
               end
            endcase
         end
      end

      // end flag: flush what is pending and go idle
      if (req_data.end_of_input) begin
         unique case (mode_in)
            M_NAME: begin
               flush_v = 1'b1;
               flush_r = pl0lex_pkg::word_result(name_new,
                            pl0lex_pkg::LEN_W'(cnt_in), saw_in);
            end
            M_NUMBER: begin
               flush_v = 1'b1;
               flush_r = pl0lex_pkg::num_result(acc_in);
            end
            M_SLASH: begin
               flush_v = 1'b1;
               flush_r = pl0lex_pkg::tok_result(pl0lex_pkg::TOK_SLASH);
            end
            M_COMMENT, M_CSTAR: begin
               flush_v = 1'b1;
               flush_r = pl0lex_pkg::err_result(pl0lex_pkg::ERR_OPEN_COMMENT);
            end
            M_LESS: begin
               flush_v = 1'b1;
               flush_r = pl0lex_pkg::tok_result(pl0lex_pkg::TOK_LES);
            end
            M_GREATER: begin
               flush_v = 1'b1;
               flush_r = pl0lex_pkg::tok_result(pl0lex_pkg::TOK_GTR);
            end
            M_COLON: begin
               flush_v = 1'b1;
               flush_r = pl0lex_pkg::err_result(pl0lex_pkg::ERR_LONE_COLON);
            end
            default: begin
               flush_v = 1'b0;
            end
         endcase
         mode_in = M_IDLE;
      end
   end

   // pack the at most two tokens of this byte in order, mark the last one
   always_comb begin
      pair.first  = cont_v ? cont_r : (start_v ? start_r : flush_r);
      pair.second = (cont_v && start_v) ? start_r : flush_r;
      pair.two    = (cont_v && start_v) || (cont_v && flush_v) || (start_v && flush_v);
      pair.first.last_of_run  = !pair.two;
      pair.second.last_of_run = 1'b1;
   end

   assign req_ready = (qcnt_ff != 2'd2);
   assign req_fire  = req_valid && req_ready;
   assign push      = req_fire && (cont_v || start_v || flush_v);

   assign head_first  = q_ff[head_ff].first;
   assign head_second = q_ff[head_ff].second;
   assign rsp_valid   = (qcnt_ff != 2'd0);
   assign rsp_data    = sel_ff ? head_second : head_first;
   assign rsp_fire    = rsp_valid && rsp_ready;
   assign pop_pair    = rsp_fire && (sel_ff || !q_ff[head_ff].two);

   always_comb begin
      qcnt_in = qcnt_ff + {1'b0, push} - {1'b0, pop_pair};
      head_in = pop_pair ? ~head_ff : head_ff;
      sel_in  = sel_ff;
      if (pop_pair) begin
         sel_in = 1'b0;
      end else if (rsp_fire) begin
         sel_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         cnt_ff  <= '0;
         saw_ff  <= 1'b0;
         dcnt_ff <= '0;
      end else if (req_fire) begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
         saw_ff  <= saw_in;
         dcnt_ff <= dcnt_in;
      end
   end

   // token text and value carry no reset, a new token always loads them
   always_ff @(posedge clock) begin
      if (req_fire) begin
         store_ff <= store_in;
         acc_ff   <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qcnt_ff <= '0;
         head_ff <= 1'b0;
         sel_ff  <= 1'b0;
      end else begin
         qcnt_ff <= qcnt_in;
         head_ff <= head_in;
         sel_ff  <= sel_in;
      end
   end

   // write at the tail slot, head plus count before this cycle's pop
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[head_ff ^ qcnt_ff[0]] <= pair;
      end
   end

endmodule
